// ===== rtl/tpbf_pkg.sv =====
// Package for the TCP destination port filter: header offsets, protocol
// constants, verdict codes and configuration register indexes.
// No dependencies; the interfaces and the top level use it.
`timescale 1ns / 1ps

package tpbf_pkg;

  // Field widths of the byte stream, the verdict and the configuration port.
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned OFFSET_W  = 16;
  localparam int unsigned LEN_W     = OFFSET_W + 1;
  localparam int unsigned STAT_W    = 32;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 16;

  // Default width of the internal saturating counters.
  localparam int unsigned COUNTER_BITS_DEFAULT = 32;

  // Ethernet and IPv4 header layout.
  localparam logic [OFFSET_W-1:0] OFF_ETYPE_HI  = 16'd12;
  localparam logic [OFFSET_W-1:0] OFF_ETYPE_LO  = 16'd13;
  localparam logic [OFFSET_W-1:0] OFF_VER_IHL   = 16'd14;
  localparam logic [OFFSET_W-1:0] OFF_TOTLEN_HI = 16'd16;
  localparam logic [OFFSET_W-1:0] OFF_TOTLEN_LO = 16'd17;
  localparam logic [OFFSET_W-1:0] OFF_PROTO     = 16'd23;
  localparam logic [OFFSET_W-1:0] OFFSET_MAX    = 16'hFFFF;

  localparam logic [LEN_W-1:0] ETH_HDR_LEN  = 17'd14;
  localparam logic [LEN_W-1:0] IP_MIN_HDR   = 17'd20;
  localparam logic [LEN_W-1:0] TCP_MIN_HDR  = 17'd20;
  // TCP destination port sits two bytes into the TCP header.
  localparam logic [OFFSET_W-1:0] TCP_DPORT_BASE = 16'd16;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [3:0]  IP_VERSION_4   = 4'd4;
  localparam logic [3:0]  IHL_MASK       = 4'hF;

  // Per-frame verdict codes.
  typedef enum logic [1:0] {
    VERDICT_FORWARD   = 2'd0,
    VERDICT_BLOCKED   = 2'd1,
    VERDICT_MALFORMED = 2'd2
  } verdict_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLOCKED_DEST_PORT = 1'b0,
    REG_OUTSIDE_PORT_ID   = 1'b1
  } cfg_reg_e;

  // Counter slots.
  localparam int unsigned CNT_TOTAL     = 0;
  localparam int unsigned CNT_BLOCKED   = 1;
  localparam int unsigned CNT_MALFORMED = 2;
  localparam int unsigned CNT_NUM       = 3;

endpackage

// ===== rtl/tpbf_byte_if.sv =====
// Valid/ready channel that carries one frame byte with its end mark and
// ingress port. Depends on tpbf_pkg.
`timescale 1ns / 1ps

interface tpbf_byte_if;
  logic                              valid;
  logic                              ready;
  logic [tpbf_pkg::BYTE_W-1:0]       frame_byte;
  logic                              frame_end;
  logic                              ingress_port;

  modport source (output valid, output frame_byte, output frame_end,
                  output ingress_port, input ready);
  modport sink   (input valid, input frame_byte, input frame_end,
                  input ingress_port, output ready);
endinterface

// ===== rtl/tpbf_verdict_if.sv =====
// Valid/ready channel that carries one frame verdict and the frame statistics.
// Depends on tpbf_pkg.
`timescale 1ns / 1ps

interface tpbf_verdict_if;
  logic                          valid;
  logic                          ready;
  tpbf_pkg::verdict_e            verdict;
  logic [tpbf_pkg::STAT_W-1:0]   total_frames;
  logic [tpbf_pkg::STAT_W-1:0]   blocked_frames;
  logic [tpbf_pkg::STAT_W-1:0]   malformed_frames;

  modport source (output valid, output verdict, output total_frames,
                  output blocked_frames, output malformed_frames, input ready);
  modport sink   (input valid, input verdict, input total_frames,
                  input blocked_frames, input malformed_frames, output ready);
endinterface

// ===== rtl/tcp_port_block_filter.sv =====
// Top level of the TCP destination port filter: byte parser, verdict logic
// and saturating frame counters. Depends on tpbf_pkg, tpbf_byte_if and
// tpbf_verdict_if.
`timescale 1ns / 1ps

// The filter takes an Ethernet frame one byte per transaction and accepts a
// new byte in every cycle, so a link can stream frames back to back. Each byte
// passes one input register and, if it ends a frame, lands in the verdict
// register, from which the verdict is offered. The result register lets the
// next frame's bytes flow in while a verdict waits to be taken. Only a last
// byte that meets a full, stalled result register holds the input. Frames
// under 14 bytes are malformed; frames from the outside port with the IPv4
// ethertype, of at least 34 bytes and with a version other than 4 are
// malformed, and well-formed outside TCP frames to the blocked port are
// dropped as blocked; all others are forwarded. The counters saturate at
// 2**COUNTER_BITS - 1 and the outputs show their low 32 bits.
module tcp_port_block_filter #(
  parameter int unsigned COUNTER_BITS = tpbf_pkg::COUNTER_BITS_DEFAULT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tpbf_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [tpbf_pkg::CFG_DAT_W-1:0]    cfg_wdata_i,
  tpbf_byte_if.sink                         frame_i,
  tpbf_verdict_if.source                    verdict_o
);

  localparam logic [COUNTER_BITS-1:0] CntMax = '1;

  // Configuration registers.
  logic [15:0] blocked_port_q;
  logic        ext_port_q;

  // Input register.
  logic                          s1_valid_q;
  logic [tpbf_pkg::BYTE_W-1:0]   s1_byte_q;
  logic                          s1_end_q;
  logic                          s1_port_q;

  // Per-frame parse state.
  logic [tpbf_pkg::OFFSET_W-1:0] off_q, off_d;
  logic [15:0]                   etype_q, etype_d;
  logic [7:0]                    vihl_q, vihl_d;
  logic [15:0]                   totlen_q, totlen_d;
  logic [7:0]                    proto_q, proto_d;
  logic [15:0]                   dport_q, dport_d;

  // Counters and result register.
  logic [COUNTER_BITS-1:0]       cnt_q [tpbf_pkg::CNT_NUM];
  logic                          out_valid_q;
  tpbf_pkg::verdict_e            verdict_q, verdict_d;

  logic                          advance;
  logic                          finish;
  logic [tpbf_pkg::OFFSET_W-1:0] dport_pos;
  logic [5:0]                    ihl_bytes;
  logic [tpbf_pkg::LEN_W-1:0]    frame_len;
  logic [63:0]                   tot_ext, blk_ext, mal_ext;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blocked_port_q <= 16'd80;
      ext_port_q     <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (tpbf_pkg::cfg_reg_e'(cfg_idx_i))
        tpbf_pkg::REG_BLOCKED_DEST_PORT: blocked_port_q <= cfg_wdata_i;
        tpbf_pkg::REG_OUTSIDE_PORT_ID:   ext_port_q     <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // The input register moves on unless it holds a last byte and the result
  // register is full and stalled.
  assign advance = s1_valid_q && (!s1_end_q || !out_valid_q || verdict_o.ready);
  assign finish  = advance && s1_end_q;
  assign frame_i.ready = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (frame_i.ready) begin
      s1_valid_q <= frame_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_i.ready && frame_i.valid) begin
      s1_byte_q <= frame_i.frame_byte;
      s1_end_q  <= frame_i.frame_end;
      s1_port_q <= frame_i.ingress_port;
    end
  end

  // Header capture for the byte in the input register.
  assign ihl_bytes = {vihl_q[3:0] & tpbf_pkg::IHL_MASK, 2'b00};
  assign dport_pos = tpbf_pkg::TCP_DPORT_BASE + tpbf_pkg::OFFSET_W'(ihl_bytes);

  always_comb begin
    etype_d  = etype_q;
    vihl_d   = vihl_q;
    totlen_d = totlen_q;
    proto_d  = proto_q;
    dport_d  = dport_q;
    off_d    = off_q;
    if (off_q != tpbf_pkg::OFFSET_MAX) begin
      if (off_q == tpbf_pkg::OFF_ETYPE_HI || off_q == tpbf_pkg::OFF_ETYPE_LO) begin
        etype_d = {etype_q[7:0], s1_byte_q};
      end
      if (off_q == tpbf_pkg::OFF_VER_IHL) begin
        vihl_d = s1_byte_q;
      end
      if (off_q == tpbf_pkg::OFF_TOTLEN_HI || off_q == tpbf_pkg::OFF_TOTLEN_LO) begin
        totlen_d = {totlen_q[7:0], s1_byte_q};
      end
      if (off_q == tpbf_pkg::OFF_PROTO) begin
        proto_d = s1_byte_q;
      end
      if (off_q == dport_pos || off_q == dport_pos + 16'd1) begin
        dport_d = {dport_q[7:0], s1_byte_q};
      end
      off_d = off_q + 16'd1;
    end
  end

  // Verdict for a frame that ends with the byte in the input register.
  logic [5:0]                 ihl_d_bytes;
  logic [tpbf_pkg::LEN_W-1:0] ihl_len;

  assign frame_len   = {1'b0, off_q} + 17'd1;
  assign ihl_d_bytes = {vihl_d[3:0] & tpbf_pkg::IHL_MASK, 2'b00};
  assign ihl_len     = tpbf_pkg::LEN_W'(ihl_d_bytes);

  always_comb begin
    priority if (frame_len < tpbf_pkg::ETH_HDR_LEN) begin
      verdict_d = tpbf_pkg::VERDICT_MALFORMED;
    end else if (s1_port_q != ext_port_q) begin
      verdict_d = tpbf_pkg::VERDICT_FORWARD;
    end else if (etype_d != tpbf_pkg::ETHERTYPE_IPV4 ||
                 frame_len < tpbf_pkg::ETH_HDR_LEN + tpbf_pkg::IP_MIN_HDR) begin
      verdict_d = tpbf_pkg::VERDICT_FORWARD;
    end else if (vihl_d[7:4] != tpbf_pkg::IP_VERSION_4) begin
      verdict_d = tpbf_pkg::VERDICT_MALFORMED;
    end else if (proto_d != tpbf_pkg::PROTO_TCP) begin
      verdict_d = tpbf_pkg::VERDICT_FORWARD;
    end else if (ihl_len < tpbf_pkg::IP_MIN_HDR) begin
      verdict_d = tpbf_pkg::VERDICT_FORWARD;
    end else if ({1'b0, totlen_d} < ihl_len + tpbf_pkg::TCP_MIN_HDR) begin
      // Negative or short TCP payload.
      verdict_d = tpbf_pkg::VERDICT_FORWARD;
    end else if (tpbf_pkg::ETH_HDR_LEN + ihl_len + tpbf_pkg::TCP_MIN_HDR > frame_len) begin
      // TCP header would run past the end of the frame.
      verdict_d = tpbf_pkg::VERDICT_FORWARD;
    end else if (dport_d == blocked_port_q) begin
      verdict_d = tpbf_pkg::VERDICT_BLOCKED;
    end else begin
      verdict_d = tpbf_pkg::VERDICT_FORWARD;
    end
  end

  // Parse state: updated per byte, cleared after the last byte of a frame.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q    <= '0;
      etype_q  <= '0;
      vihl_q   <= '0;
      totlen_q <= '0;
      proto_q  <= '0;
      dport_q  <= '0;
    end else if (finish) begin
      off_q    <= '0;
      etype_q  <= '0;
      vihl_q   <= '0;
      totlen_q <= '0;
      proto_q  <= '0;
      dport_q  <= '0;
    end else if (advance) begin
      off_q    <= off_d;
      etype_q  <= etype_d;
      vihl_q   <= vihl_d;
      totlen_q <= totlen_d;
      proto_q  <= proto_d;
      dport_q  <= dport_d;
    end
  end

  // Saturating counters, bumped together with the verdict load.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q[tpbf_pkg::CNT_TOTAL]     <= '0;
      cnt_q[tpbf_pkg::CNT_BLOCKED]   <= '0;
      cnt_q[tpbf_pkg::CNT_MALFORMED] <= '0;
    end else if (finish) begin
      if (cnt_q[tpbf_pkg::CNT_TOTAL] != CntMax) begin
        cnt_q[tpbf_pkg::CNT_TOTAL] <= cnt_q[tpbf_pkg::CNT_TOTAL] + 1'b1;
      end
      if (verdict_d == tpbf_pkg::VERDICT_BLOCKED &&
          cnt_q[tpbf_pkg::CNT_BLOCKED] != CntMax) begin
        cnt_q[tpbf_pkg::CNT_BLOCKED] <= cnt_q[tpbf_pkg::CNT_BLOCKED] + 1'b1;
      end
      if (verdict_d == tpbf_pkg::VERDICT_MALFORMED &&
          cnt_q[tpbf_pkg::CNT_MALFORMED] != CntMax) begin
        cnt_q[tpbf_pkg::CNT_MALFORMED] <= cnt_q[tpbf_pkg::CNT_MALFORMED] + 1'b1;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish) begin
      out_valid_q <= 1'b1;
    end else if (verdict_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      verdict_q <= verdict_d;
    end
  end

  // Counters change only when a new verdict loads, so they serve as payload.
  assign tot_ext = 64'(cnt_q[tpbf_pkg::CNT_TOTAL]);
  assign blk_ext = 64'(cnt_q[tpbf_pkg::CNT_BLOCKED]);
  assign mal_ext = 64'(cnt_q[tpbf_pkg::CNT_MALFORMED]);

  assign verdict_o.valid            = out_valid_q;
  assign verdict_o.verdict          = verdict_q;
  assign verdict_o.total_frames     = tot_ext[tpbf_pkg::STAT_W-1:0];
  assign verdict_o.blocked_frames   = blk_ext[tpbf_pkg::STAT_W-1:0];
  assign verdict_o.malformed_frames = mal_ext[tpbf_pkg::STAT_W-1:0];

  // A malformed verdict implies the malformed counter has counted it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && verdict_q == tpbf_pkg::VERDICT_MALFORMED)
      |-> (cnt_q[tpbf_pkg::CNT_MALFORMED] != '0))
    else $error("malformed verdict without malformed count");

  // A blocked verdict implies the blocked counter has counted it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && verdict_q == tpbf_pkg::VERDICT_BLOCKED)
      |-> (cnt_q[tpbf_pkg::CNT_BLOCKED] != '0))
    else $error("blocked verdict without blocked count");

  // Each finished frame restarts parsing at offset zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> (off_q == '0))
    else $error("byte offset not cleared after frame end");

  // A stalled verdict keeps the input side from finishing another frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !verdict_o.ready) |-> !finish)
    else $error("verdict overwritten while stalled");

endmodule

// ===== verif/tcp_port_block_filter_test.sv =====
// Self-checking testbench for the TCP destination port filter: directed frames, then
// random well-formed, damaged and noise frames under several filter settings.
// Depends on tpbf_pkg, tpbf_byte_if, tpbf_verdict_if and tcp_port_block_filter.
`timescale 1ns / 1ps

module tcp_port_block_filter_test;

  localparam int unsigned CNT_W             = tpbf_pkg::COUNTER_BITS_DEFAULT;
  localparam int unsigned LEN_W             = tpbf_pkg::LEN_W;
  localparam int unsigned OFF_W             = tpbf_pkg::OFFSET_W;
  localparam int unsigned STAT_W            = tpbf_pkg::STAT_W;
  // Bytes for the random part; the directed frames add about 950 more.
  localparam int unsigned RANDOM_ITEMS      = 550;
  localparam int unsigned RANDOM_MIN_FRAMES = 8;
  localparam int unsigned FRAMES_PER_SETUP  = 3;
  localparam int unsigned SETTLE_CYCLES     = 6;
  localparam int unsigned WATCHDOG_CYCLES   = 4000;
  localparam logic [15:0] ETHERTYPE_IPV6    = 16'h86DD;
  localparam logic [7:0]  PROTO_UDP         = 8'd17;
  localparam logic [15:0] DEFAULT_PORT      = 16'd80;

  // Short names for the directed table.
  localparam logic [15:0]        ET_IP4 = tpbf_pkg::ETHERTYPE_IPV4;
  localparam logic [7:0]         P_TCP  = tpbf_pkg::PROTO_TCP;
  localparam tpbf_pkg::verdict_e V_FWD  = tpbf_pkg::VERDICT_FORWARD;
  localparam tpbf_pkg::verdict_e V_BLK  = tpbf_pkg::VERDICT_BLOCKED;
  localparam tpbf_pkg::verdict_e V_MAL  = tpbf_pkg::VERDICT_MALFORMED;

  // One frame to send, with an optional hand-written verdict.
  typedef struct packed {
    logic [16:0]        frame_len;
    logic [15:0]        etype;
    logic [3:0]         ip_ver;
    logic [3:0]         ihl;
    logic [15:0]        ip_len;
    logic [7:0]         proto;
    logic [15:0]        dport;
    logic               last_port;
    logic               listed;
    tpbf_pkg::verdict_e verdict;
  } frame_spec_t;

  typedef struct packed {
    logic               known;
    tpbf_pkg::verdict_e verdict;
  } listed_verdict_t;

  typedef struct packed {
    tpbf_pkg::verdict_e   verdict;
    logic [STAT_W-1:0]    total;
    logic [STAT_W-1:0]    blocked;
    logic [STAT_W-1:0]    malformed;
  } verdict_record_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [tpbf_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [tpbf_pkg::CFG_DAT_W-1:0] cfg_wdata_i;

  tpbf_byte_if    frame_if ();
  tpbf_verdict_if verdict_if ();

  tcp_port_block_filter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .frame_i     (frame_if),
    .verdict_o   (verdict_if)
  );

  // Shadow copy of the filter settings and of the per-frame parser state.
  logic [15:0]       blocked_port = DEFAULT_PORT;
  logic              ext_port = 1'b1;
  logic [15:0]       frame_off;
  logic [15:0]       etype_seen;
  logic [7:0]        ver_ihl_seen;
  logic [15:0]       ip_len_seen;
  logic [7:0]        proto_seen;
  logic [15:0]       dport_seen;
  logic [CNT_W-1:0]  frame_tally [tpbf_pkg::CNT_NUM];

  verdict_record_t   pending_verdicts [$];
  listed_verdict_t   listed_verdicts [$];
  int unsigned       fail_count;
  int unsigned       frames_sent;
  int unsigned       bytes_sent;
  int                send_quiet;
  int                take_quiet;
  int unsigned       idle_cycles;

  // Directed frames under the reset settings (port 80 blocked, port 1 outside).
  localparam int N_DIRECTED = 20;
  frame_spec_t directed_frames [N_DIRECTED] = '{
    // Single byte and one byte short of an Ethernet header.
    '{17'd1, ET_IP4, 4'd4, 4'd5, 16'd40, P_TCP, DEFAULT_PORT, 1'b1, 1'b1, V_MAL},
    '{17'd13, ET_IP4, 4'd4, 4'd5, 16'd40, P_TCP, DEFAULT_PORT, 1'b1, 1'b1, V_MAL},
    // Ethernet header only, and an IPv4 header cut short even with a bad version.
    '{17'd14, ET_IP4, 4'd4, 4'd5, 16'd40, P_TCP, DEFAULT_PORT, 1'b1, 1'b1, V_FWD},
    '{17'd33, ET_IP4, 4'd6, 4'd5, 16'd40, P_TCP, DEFAULT_PORT, 1'b1, 1'b1, V_FWD},
    // Minimal TCP frame to the blocked port, from outside and from inside.
    '{17'd54, ET_IP4, 4'd4, 4'd5, 16'd40, P_TCP, DEFAULT_PORT, 1'b1, 1'b1, V_BLK},
    '{17'd54, ET_IP4, 4'd4, 4'd5, 16'd40, P_TCP, DEFAULT_PORT, 1'b0, 1'b1, V_FWD},
    // Wrong IP version.
    '{17'd54, ET_IP4, 4'd6, 4'd5, 16'd40, P_TCP, DEFAULT_PORT, 1'b1, 1'b1, V_MAL},
    '{17'd54, ET_IP4, 4'd15, 4'd5, 16'd40, P_TCP, DEFAULT_PORT, 1'b1, 1'b1, V_MAL},
    // Not IPv4, not TCP, other port.
    '{17'd54, ETHERTYPE_IPV6, 4'd6, 4'd5, 16'd40, P_TCP, DEFAULT_PORT, 1'b1, 1'b1, V_FWD},
    '{17'd54, ET_IP4, 4'd4, 4'd5, 16'd40, PROTO_UDP, DEFAULT_PORT, 1'b1, 1'b1, V_FWD},
    '{17'd54, ET_IP4, 4'd4, 4'd5, 16'd40, P_TCP, 16'd81, 1'b1, 1'b1, V_FWD},
    // IHL too small, negative payload, payload under a TCP header, TCP past frame end.
    '{17'd54, ET_IP4, 4'd4, 4'd4, 16'd40, P_TCP, DEFAULT_PORT, 1'b1, 1'b1, V_FWD},
    '{17'd54, ET_IP4, 4'd4, 4'd5, 16'd16, P_TCP, DEFAULT_PORT, 1'b1, 1'b1, V_FWD},
    '{17'd54, ET_IP4, 4'd4, 4'd5, 16'd39, P_TCP, DEFAULT_PORT, 1'b1, 1'b1, V_FWD},
    '{17'd53, ET_IP4, 4'd4, 4'd5, 16'd40, P_TCP, DEFAULT_PORT, 1'b1, 1'b1, V_FWD},
    // Largest IHL, and largest total length.
    '{17'd94, ET_IP4, 4'd4, 4'd15, 16'd80, P_TCP, DEFAULT_PORT, 1'b1, 1'b1, V_BLK},
    '{17'd60, ET_IP4, 4'd4, 4'd5, 16'hFFFF, P_TCP, DEFAULT_PORT, 1'b1, 1'b1, V_BLK},
    // Zero IHL puts the port field on top of the length field.
    '{17'd54, ET_IP4, 4'd4, 4'd0, 16'd0, P_TCP, 16'd0, 1'b1, 1'b0, V_FWD},
    // All-ones and all-zero header fields.
    '{17'd70, 16'hFFFF, 4'hF, 4'hF, 16'hFFFF, 8'hFF, 16'hFFFF, 1'b1, 1'b0, V_FWD},
    '{17'd20, 16'h0000, 4'h0, 4'h0, 16'h0000, 8'h00, 16'h0000, 1'b0, 1'b0, V_FWD}
  };

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Gap length: mostly none or short, a few long, with quiet stretches of none.
  function automatic int pick_gap(inout int quiet_left);
    int roll;
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    if ($urandom_range(0, 49) == 0) begin
      quiet_left = $urandom_range(20, 80);
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic void bump_tally(input int unsigned slot);
    if (frame_tally[slot] != '1) frame_tally[slot]++;
  endfunction

  // Frame verdict from the captured header fields and the frame length.
  function automatic tpbf_pkg::verdict_e judge_frame(input logic [LEN_W-1:0] len,
                                                     input logic port_in);
    logic [LEN_W-1:0] hdr_bytes;
    hdr_bytes = LEN_W'({ver_ihl_seen[3:0] & tpbf_pkg::IHL_MASK, 2'b00});
    if (len < tpbf_pkg::ETH_HDR_LEN) return tpbf_pkg::VERDICT_MALFORMED;
    if (port_in != ext_port) return tpbf_pkg::VERDICT_FORWARD;
    if (etype_seen != tpbf_pkg::ETHERTYPE_IPV4 ||
        len - tpbf_pkg::ETH_HDR_LEN < tpbf_pkg::IP_MIN_HDR)
      return tpbf_pkg::VERDICT_FORWARD;
    if (ver_ihl_seen[7:4] != tpbf_pkg::IP_VERSION_4) return tpbf_pkg::VERDICT_MALFORMED;
    if (proto_seen != tpbf_pkg::PROTO_TCP) return tpbf_pkg::VERDICT_FORWARD;
    if (hdr_bytes < tpbf_pkg::IP_MIN_HDR) return tpbf_pkg::VERDICT_FORWARD;
    if (LEN_W'(ip_len_seen) < hdr_bytes ||
        LEN_W'(ip_len_seen) - hdr_bytes < tpbf_pkg::TCP_MIN_HDR)
      return tpbf_pkg::VERDICT_FORWARD;
    if (tpbf_pkg::ETH_HDR_LEN + hdr_bytes + tpbf_pkg::TCP_MIN_HDR > len)
      return tpbf_pkg::VERDICT_FORWARD;
    if (dport_seen == blocked_port) return tpbf_pkg::VERDICT_BLOCKED;
    return tpbf_pkg::VERDICT_FORWARD;
  endfunction

  // Advance the shadow parser by one accepted byte; a final byte yields a verdict.
  function automatic void track_frame_byte(input logic [7:0] octet, input logic last,
                                           input logic port_in);
    logic [OFF_W-1:0]   off;
    logic [OFF_W-1:0]   dport_at;
    tpbf_pkg::verdict_e verdict;
    listed_verdict_t    listed;
    verdict_record_t    record;
    off      = frame_off;
    dport_at = tpbf_pkg::TCP_DPORT_BASE + OFF_W'({ver_ihl_seen[3:0], 2'b00});
    if (off != tpbf_pkg::OFFSET_MAX) begin
      if (off == tpbf_pkg::OFF_ETYPE_HI || off == tpbf_pkg::OFF_ETYPE_LO)
        etype_seen = {etype_seen[7:0], octet};
      if (off == tpbf_pkg::OFF_VER_IHL) ver_ihl_seen = octet;
      if (off == tpbf_pkg::OFF_TOTLEN_HI || off == tpbf_pkg::OFF_TOTLEN_LO)
        ip_len_seen = {ip_len_seen[7:0], octet};
      if (off == tpbf_pkg::OFF_PROTO) proto_seen = octet;
      if (off == dport_at || 32'(off) == 32'(dport_at) + 1)
        dport_seen = {dport_seen[7:0], octet};
      frame_off = off + 1'b1;
    end
    if (!last) return;

    verdict = judge_frame(LEN_W'(off) + 1'b1, port_in);
    // Directed frames may carry a verdict written out by hand.
    if (listed_verdicts.size() != 0) begin
      listed = listed_verdicts.pop_front();
      if (listed.known) verdict = listed.verdict;
    end
    bump_tally(tpbf_pkg::CNT_TOTAL);
    if (verdict == tpbf_pkg::VERDICT_BLOCKED) bump_tally(tpbf_pkg::CNT_BLOCKED);
    else if (verdict == tpbf_pkg::VERDICT_MALFORMED) bump_tally(tpbf_pkg::CNT_MALFORMED);

    record.verdict   = verdict;
    record.total     = STAT_W'(frame_tally[tpbf_pkg::CNT_TOTAL]);
    record.blocked   = STAT_W'(frame_tally[tpbf_pkg::CNT_BLOCKED]);
    record.malformed = STAT_W'(frame_tally[tpbf_pkg::CNT_MALFORMED]);
    pending_verdicts.push_back(record);

    frame_off    = '0;
    etype_seen   = '0;
    ver_ihl_seen = '0;
    ip_len_seen  = '0;
    proto_seen   = '0;
    dport_seen   = '0;
  endfunction

  function automatic void check_field(input string field, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      fail_count++;
    end
  endfunction

  // Random frame: mostly well-formed TCP, some with one field damaged, a few pure noise.
  function automatic frame_spec_t random_frame();
    frame_spec_t  s;
    int unsigned  hdr;
    int unsigned  pick;
    s.etype     = tpbf_pkg::ETHERTYPE_IPV4;
    s.ip_ver    = tpbf_pkg::IP_VERSION_4;
    s.proto     = tpbf_pkg::PROTO_TCP;
    s.ihl       = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(5, 15)) : 4'd5;
    hdr         = s.ihl * 4;
    s.ip_len    = 16'(hdr + 20 + $urandom_range(0, 40));
    s.frame_len = 17'(14 + hdr + 20 + $urandom_range(0, 6));
    s.dport     = ($urandom_range(0, 1) == 1) ? blocked_port : 16'($urandom);
    s.last_port = ($urandom_range(0, 3) != 0) ? ext_port : ~ext_port;
    s.listed    = 1'b0;
    s.verdict   = tpbf_pkg::VERDICT_FORWARD;
    pick = $urandom_range(0, 19);
    if (pick >= 13 && pick <= 18) begin
      unique case (pick - 13)
        0: s.ip_ver    = 4'($urandom);
        1: s.ihl       = 4'($urandom_range(0, 4));
        2: s.ip_len    = 16'($urandom_range(0, hdr + 19));
        3: s.proto     = 8'($urandom);
        4: s.frame_len = 17'($urandom_range(1, 14 + hdr + 19));
        default: s.etype = 16'($urandom);
      endcase
    end else if (pick == 19) begin
      s.frame_len = 17'($urandom_range(1, 80));
      s.etype     = 16'($urandom);
      s.ip_ver    = 4'($urandom);
      s.ihl       = 4'($urandom);
      s.ip_len    = 16'($urandom);
      s.proto     = 8'($urandom);
      s.dport     = 16'($urandom);
      s.last_port = 1'($urandom);
    end
    return s;
  endfunction

  // Offer one byte, after an optional gap, and hold it until accepted.
  task automatic push_byte(input logic [7:0] octet, input logic last, input logic port_in);
    int gap;
    gap = pick_gap(send_quiet);
    if (gap > 0) begin
      frame_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    frame_if.valid        <= 1'b1;
    frame_if.frame_byte   <= octet;
    frame_if.frame_end    <= last;
    frame_if.ingress_port <= port_in;
    do @(posedge clk_i); while (!frame_if.ready);
  endtask

  // Lay the header fields over random bytes and stream the frame.
  task automatic send_frame(input frame_spec_t s);
    logic [15:0] dport_at;
    logic [7:0]  octet;
    logic        last;
    dport_at = tpbf_pkg::TCP_DPORT_BASE + {10'd0, s.ihl, 2'b00};
    for (int i = 0; i < int'(s.frame_len); i++) begin
      octet = 8'($urandom);
      unique case (i)
        tpbf_pkg::OFF_ETYPE_HI:  octet = s.etype[15:8];
        tpbf_pkg::OFF_ETYPE_LO:  octet = s.etype[7:0];
        tpbf_pkg::OFF_VER_IHL:   octet = {s.ip_ver, s.ihl};
        tpbf_pkg::OFF_TOTLEN_HI: octet = s.ip_len[15:8];
        tpbf_pkg::OFF_TOTLEN_LO: octet = s.ip_len[7:0];
        tpbf_pkg::OFF_PROTO:     octet = s.proto;
        default: ;
      endcase
      if (i == int'(dport_at)) octet = s.dport[15:8];
      if (i == int'(dport_at) + 1) octet = s.dport[7:0];
      last = (i == int'(s.frame_len) - 1);
      push_byte(octet, last, last ? s.last_port : 1'($urandom));
    end
    frames_sent++;
    bytes_sent += s.frame_len;
  endtask

  // Stop sending and wait until every pending verdict has been taken.
  task automatic drain_results();
    frame_if.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write both filter registers; only called while the block is idle.
  task automatic apply_filter_config(input logic [15:0] port_no, input logic outside);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= tpbf_pkg::REG_BLOCKED_DEST_PORT;
    cfg_wdata_i <= port_no;
    @(posedge clk_i);
    cfg_idx_i   <= tpbf_pkg::REG_OUTSIDE_PORT_ID;
    cfg_wdata_i <= tpbf_pkg::CFG_DAT_W'(outside);
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    blocked_port = port_no;
    ext_port     = outside;
  endtask

  // Receiver: random stalls on the verdict channel.
  initial begin
    int gap;
    verdict_if.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      gap = pick_gap(take_quiet);
      if (gap > 0) begin
        verdict_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      verdict_if.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  end

  // Input monitor feeds the shadow parser with every accepted byte.
  always @(posedge clk_i) begin
    if (rst_ni && frame_if.valid && frame_if.ready)
      track_frame_byte(frame_if.frame_byte, frame_if.frame_end, frame_if.ingress_port);
  end

  // Output monitor compares each verdict transaction with the oldest pending one.
  always @(posedge clk_i) begin
    verdict_record_t want;
    if (rst_ni && verdict_if.valid && verdict_if.ready) begin
      if (pending_verdicts.size() == 0) begin
        $error("verdict transaction with no frame pending");
        fail_count++;
      end else begin
        want = pending_verdicts.pop_front();
        check_field("verdict", 32'(want.verdict), 32'(verdict_if.verdict));
        check_field("total_frames", want.total, verdict_if.total_frames);
        check_field("blocked_frames", want.blocked, verdict_if.blocked_frames);
        check_field("malformed_frames", want.malformed, verdict_if.malformed_frames);
      end
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk_i) begin
    if ((frame_if.valid && frame_if.ready) || (verdict_if.valid && verdict_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Main sequence: reset, directed frames, random frames under changing settings.
  initial begin
    int unsigned setup_step;
    rst_ni                <= 1'b0;
    cfg_we_i              <= 1'b0;
    cfg_idx_i             <= tpbf_pkg::REG_BLOCKED_DEST_PORT;
    cfg_wdata_i           <= '0;
    frame_if.valid        <= 1'b0;
    frame_if.frame_byte   <= '0;
    frame_if.frame_end    <= 1'b0;
    frame_if.ingress_port <= 1'b0;
    frame_off    = '0;
    etype_seen   = '0;
    ver_ihl_seen = '0;
    ip_len_seen  = '0;
    proto_seen   = '0;
    dport_seen   = '0;
    foreach (frame_tally[i]) frame_tally[i] = '0;
    fail_count  = 0;
    send_quiet  = 0;
    take_quiet  = 0;
    setup_step  = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_frames[i]) begin
      listed_verdicts.push_back('{directed_frames[i].listed, directed_frames[i].verdict});
      send_frame(directed_frames[i]);
    end

    frames_sent = 0;
    bytes_sent  = 0;
    while (bytes_sent < RANDOM_ITEMS || frames_sent < RANDOM_MIN_FRAMES) begin
      if (frames_sent % FRAMES_PER_SETUP == 0) begin
        drain_results();
        unique case (setup_step % 4)
          0: apply_filter_config(16'h0000, (setup_step % 3) != 0);
          1: apply_filter_config(16'hFFFF, (setup_step % 3) != 0);
          default: apply_filter_config(16'($urandom), (setup_step % 3) != 0);
        endcase
        setup_step++;
      end
      send_frame(random_frame());
    end

    drain_results();
    if (fail_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
